### rtl/fspc_pkg.sv
// shared types, codes and decode helpers of the five-stage pipelined cpu
package fspc_pkg;

  // memory and register file sizes
  localparam int unsigned MemWordsDef = 65536;
  localparam int unsigned RegCount    = 8;
  localparam int unsigned RegAw       = 3;

  // transaction function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_STEP  = 2'd1;
  localparam logic [1:0] FN_RDMEM = 2'd2;
  localparam logic [1:0] FN_RDREG = 2'd3;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NOR  = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_HALT = 3'd6;
  localparam logic [2:0] OP_NOOP = 3'd7;

  localparam logic [31:0] NoopWord = {7'd0, OP_NOOP, 22'd0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_ISSUE,
    ST_EXEC,
    ST_DONE
  } fspc_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic idx;
    logic issue;
    logic exec;
  } fspc_cmd_t;

  // destination register of a writing instruction
  typedef struct packed {
    logic             vld;
    logic [RegAw-1:0] rd;
  } fspc_dest_t;

  function automatic logic [2:0] op_of(logic [31:0] w);
    return w[24:22];
  endfunction

  function automatic logic [RegAw-1:0] ra_of(logic [31:0] w);
    return w[21:19];
  endfunction

  function automatic logic [RegAw-1:0] rb_of(logic [31:0] w);
    return w[18:16];
  endfunction

  function automatic fspc_dest_t dest_of(logic [31:0] w, logic with_lw);
    fspc_dest_t r;
    r.vld = 1'b0;
    r.rd  = w[2:0];
    if (op_of(w) == OP_ADD || op_of(w) == OP_NOR) begin
      r.vld = 1'b1;
    end else if (with_lw && op_of(w) == OP_LW) begin
      r.vld = 1'b1;
      r.rd  = rb_of(w);
    end
    return r;
  endfunction

endpackage

### rtl/five_stage_pipelined_cpu.sv
// top level of the five-stage pipelined cpu
//
// channel   | handshake              | payload
// command   | start_i, busy_o        | func_i, address_i, word_data_i
// result    | done_o (one cycle)     | read_value_o, halted_o, cycle_count_o,
//           |                        | program_counter_o
//
// after acceptance every transaction runs through address reduction,
// memory and register file read issue, execute, then the result strobe;
// the registered memory read sets the length.
// reset clears the pipeline, pc, cycle count and register file valid bits.
// the receiver cannot stall; busy_o is high until the result cycle ends.
module five_stage_pipelined_cpu #(
  parameter int unsigned MEM_WORDS = fspc_pkg::MemWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [31:0] word_data_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic        halted_o,
  output logic [31:0] cycle_count_o,
  output logic [15:0] program_counter_o
);
  import fspc_pkg::*;

  fspc_cmd_t cmd;

  // controller
  fspc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  // datapath
  fspc_datapath #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (func_i),
    .address_i        (address_i),
    .word_data_i      (word_data_i),
    .read_value_o     (read_value_o),
    .halted_o         (halted_o),
    .cycle_count_o    (cycle_count_o),
    .program_counter_o(program_counter_o)
  );

endmodule

### rtl/fspc_ctrl.sv
// sequencer for one transaction: index, memory issue, execute, result strobe
module fspc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output fspc_pkg::fspc_cmd_t cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import fspc_pkg::*;

  fspc_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_IDX;
      ST_IDX:   state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.latch = (state_q == ST_IDLE) && start_i;
    cmd_o.idx   = (state_q == ST_IDX);
    cmd_o.issue = (state_q == ST_ISSUE);
    cmd_o.exec  = (state_q == ST_EXEC);
    busy_o      = (state_q != ST_IDLE);
    done_o      = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/fspc_datapath.sv
// memories, register file and pipeline registers with forwarding and hazard logic
module fspc_datapath #(
  parameter int unsigned MEM_WORDS = fspc_pkg::MemWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fspc_pkg::fspc_cmd_t cmd_i,
  input  logic [1:0]          func_i,
  input  logic [15:0]         address_i,
  input  logic [31:0]         word_data_i,
  output logic [31:0]         read_value_o,
  output logic                halted_o,
  output logic [31:0]         cycle_count_o,
  output logic [15:0]         program_counter_o
);
  import fspc_pkg::*;

  localparam int unsigned Aw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [63:0] Recip = ((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [31:0] MemW  = 32'(MEM_WORDS);

  // latched transaction
  logic [1:0]  func_q;
  logic [15:0] addr_q;
  logic [31:0] word_q;

  // architectural pipeline state
  logic [15:0] pc_q, ifid_pc_q, idex_pc1_q, exmem_tgt_q;
  logic [31:0] cyc_q;
  logic [31:0] ifid_instr_q, idex_instr_q, idex_va_q, idex_vb_q, idex_off_q;
  logic [31:0] exmem_instr_q, exmem_alu_q, exmem_valb_q;
  logic        exmem_eq_q;
  logic [31:0] memwb_instr_q, memwb_data_q, wbend_instr_q, wbend_data_q;
  logic [31:0] read_value_q;

  // memories and register file
  logic [31:0] imem [MEM_WORDS];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] rf_mem [RegCount];
  logic [RegCount-1:0] rf_vld_q;
  logic [31:0] imem_rd_q, dmem_rd_q, rfa_q, rfb_q;

  // address reduction: quotient by reciprocal, then remainder
  logic [15:0] data_addr;
  logic [47:0] pc_prod, da_prod;
  logic [15:0] pc_quo_q, da_quo_q;
  logic [31:0] pc_rem, da_rem;
  logic [Aw-1:0] pc_ix, da_ix, da_ix_q;

  assign data_addr = (func_q == FN_STEP) ? exmem_alu_q[15:0] : addr_q;
  assign pc_prod   = 48'(pc_q) * Recip[47:0];
  assign da_prod   = 48'(data_addr) * Recip[47:0];
  assign pc_rem    = 32'(pc_q) - 32'(pc_quo_q) * MemW;
  assign da_rem    = 32'(data_addr) - 32'(da_quo_q) * MemW;
  assign pc_ix     = pc_rem[Aw-1:0];
  assign da_ix     = da_rem[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      addr_q <= address_i;
      word_q <= word_data_i;
    end
    if (cmd_i.idx) begin
      pc_quo_q <= pc_prod[47:32];
      da_quo_q <= da_prod[47:32];
    end
    if (cmd_i.issue) begin
      da_ix_q <= da_ix;
    end
  end

  // step control
  logic step_go, taken, stall, wb_en, sw_en;
  logic [31:0] f;
  logic [RegAw-1:0] lw_d;
  assign step_go = cmd_i.exec && (func_q == FN_STEP) && (op_of(memwb_instr_q) != OP_HALT);
  assign taken   = (op_of(exmem_instr_q) == OP_BEQ) && exmem_eq_q;
  assign f       = imem_rd_q;
  assign lw_d    = rb_of(ifid_instr_q);

  // load-use hazard detect
  always_comb begin
    stall = 1'b0;
    if (op_of(ifid_instr_q) == OP_LW) begin
      if (op_of(f) == OP_ADD || op_of(f) == OP_NOR || op_of(f) == OP_SW ||
          op_of(f) == OP_BEQ) begin
        stall = (lw_d == ra_of(f)) || (lw_d == rb_of(f));
      end else if (op_of(f) == OP_LW) begin
        stall = (lw_d == ra_of(f));
      end
    end
  end

  // fetch and decode next values
  logic [15:0] n_pc, n_ifid_pc;
  logic [31:0] n_ifid, n_off;
  always_comb begin
    n_ifid_pc = pc_q + 16'd1;
    n_pc      = n_ifid_pc;
    n_ifid    = f;
    if (taken) begin
      n_pc      = exmem_tgt_q;
      n_ifid_pc = exmem_tgt_q;
      n_ifid    = NoopWord;
    end else if (stall) begin
      n_pc   = pc_q;
      n_ifid = NoopWord;
    end
    n_off = (op_of(ifid_instr_q) == OP_NOOP) ? 32'd0
          : {{16{ifid_instr_q[15]}}, ifid_instr_q[15:0]};
  end

  // execute with forwarding, newest source applied last
  logic [31:0] opa, opb, n_alu;
  fspc_dest_t  d_wbend, d_memwb, d_exmem;
  assign d_wbend = dest_of(wbend_instr_q, 1'b1);
  assign d_memwb = dest_of(memwb_instr_q, 1'b1);
  assign d_exmem = dest_of(exmem_instr_q, 1'b0);
  always_comb begin
    opa = idex_va_q;
    opb = idex_vb_q;
    if (d_wbend.vld && d_wbend.rd == ra_of(idex_instr_q)) opa = wbend_data_q;
    if (d_wbend.vld && d_wbend.rd == rb_of(idex_instr_q)) opb = wbend_data_q;
    if (d_memwb.vld && d_memwb.rd == ra_of(idex_instr_q)) opa = memwb_data_q;
    if (d_memwb.vld && d_memwb.rd == rb_of(idex_instr_q)) opb = memwb_data_q;
    if (d_exmem.vld && d_exmem.rd == ra_of(idex_instr_q)) opa = exmem_alu_q;
    if (d_exmem.vld && d_exmem.rd == rb_of(idex_instr_q)) opb = exmem_alu_q;
    unique case (op_of(idex_instr_q))
      OP_ADD:        n_alu = opa + opb;
      OP_NOR:        n_alu = ~(opa | opb);
      OP_LW, OP_SW:  n_alu = opa + idex_off_q;
      default:       n_alu = 32'd0;
    endcase
  end

  // memory stage result and writeback
  logic [31:0] n_wd;
  assign n_wd  = (op_of(exmem_instr_q) == OP_LW) ? dmem_rd_q
               : (d_exmem.vld ? exmem_alu_q : 32'd0);
  assign sw_en = step_go && (op_of(exmem_instr_q) == OP_SW);
  assign wb_en = step_go && d_memwb.vld;

  // instruction memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && func_q == FN_LOAD) imem[da_ix] <= word_q;
    if (cmd_i.issue) imem_rd_q <= imem[pc_ix];
  end

  // data memory, one write port shared by load and store
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && func_q == FN_LOAD) begin
      dmem[da_ix] <= word_q;
    end else if (sw_en) begin
      dmem[da_ix_q] <= exmem_valb_q;
    end
    if (cmd_i.issue) dmem_rd_q <= dmem[da_ix];
  end

  // register file
  logic [RegAw-1:0] rfa_addr, rfb_addr;
  assign rfa_addr = (func_q == FN_RDREG) ? addr_q[RegAw-1:0] : ra_of(ifid_instr_q);
  assign rfb_addr = rb_of(ifid_instr_q);
  always_ff @(posedge clk_i) begin
    if (wb_en) rf_mem[d_memwb.rd] <= memwb_data_q;
    if (cmd_i.issue) begin
      rfa_q <= rf_vld_q[rfa_addr] ? rf_mem[rfa_addr] : 32'd0;
      rfb_q <= rf_vld_q[rfb_addr] ? rf_mem[rfb_addr] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wb_en) begin
      rf_vld_q[d_memwb.rd] <= 1'b1;
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= '0;
      cyc_q         <= '0;
      ifid_instr_q  <= NoopWord;
      ifid_pc_q     <= '0;
      idex_instr_q  <= NoopWord;
      idex_va_q     <= '0;
      idex_vb_q     <= '0;
      idex_pc1_q    <= '0;
      idex_off_q    <= '0;
      exmem_instr_q <= NoopWord;
      exmem_tgt_q   <= '0;
      exmem_eq_q    <= 1'b0;
      exmem_alu_q   <= '0;
      exmem_valb_q  <= '0;
      memwb_instr_q <= NoopWord;
      memwb_data_q  <= '0;
      wbend_instr_q <= NoopWord;
      wbend_data_q  <= '0;
    end else if (step_go) begin
      pc_q          <= n_pc;
      cyc_q         <= cyc_q + 32'd1;
      ifid_instr_q  <= n_ifid;
      ifid_pc_q     <= n_ifid_pc;
      idex_instr_q  <= taken ? NoopWord : ifid_instr_q;
      idex_va_q     <= rfa_q;
      idex_vb_q     <= rfb_q;
      idex_pc1_q    <= ifid_pc_q;
      idex_off_q    <= n_off;
      exmem_instr_q <= taken ? NoopWord : idex_instr_q;
      exmem_tgt_q   <= idex_off_q[15:0] + idex_pc1_q;
      exmem_eq_q    <= (opa == opb);
      exmem_alu_q   <= n_alu;
      exmem_valb_q  <= opb;
      memwb_instr_q <= exmem_instr_q;
      memwb_data_q  <= n_wd;
      wbend_instr_q <= memwb_instr_q;
      wbend_data_q  <= memwb_data_q;
    end
  end

  // read result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      unique case (func_q)
        FN_RDMEM: read_value_q <= dmem_rd_q;
        FN_RDREG: read_value_q <= (addr_q < 16'(RegCount)) ? rfa_q : 32'd0;
        default:  read_value_q <= 32'd0;
      endcase
    end
  end

  assign read_value_o      = read_value_q;
  assign halted_o          = (op_of(memwb_instr_q) == OP_HALT);
  assign cycle_count_o     = cyc_q;
  assign program_counter_o = pc_q;

endmodule

### rtl/fspc_checker.sv
// port-level checks of the five-stage pipelined cpu and their binding
module fspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        halted_o,
  input logic [31:0] cycle_count_o,
  input logic [15:0] program_counter_o
);

  // an accepted transaction gives its result after the index, issue and execute states
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result strobe missing after accepted transaction");

  // the result strobe lasts a single cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // no result without a transaction in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  // once halted the machine state holds
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_o |=> (halted_o && $stable(cycle_count_o) && $stable(program_counter_o)))
    else $error("state moved after halt");

endmodule

bind five_stage_pipelined_cpu fspc_checker u_fspc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .halted_o         (halted_o),
  .cycle_count_o    (cycle_count_o),
  .program_counter_o(program_counter_o)
);

### tb/sv/tb_five_stage_pipelined_cpu.sv
// self-checking testbench of the five-stage pipelined cpu with its own pipeline predictor
module tb_five_stage_pipelined_cpu;
  import fspc_pkg::*;

  localparam logic [2:0] OpJalr = 3'd5;

  typedef struct packed {
    logic [31:0] read_value;
    logic        halted;
    logic [31:0] cycle_count;
    logic [15:0] program_counter;
  } cpu_res_t;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [31:0] data;
    bit          typed;
    cpu_res_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [15:0] address_i;
  logic [31:0] word_data_i;
  logic        done_o;
  logic [31:0] read_value_o;
  logic        halted_o;
  logic [31:0] cycle_count_o;
  logic [15:0] program_counter_o;

  five_stage_pipelined_cpu dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .address_i         (address_i),
    .word_data_i       (word_data_i),
    .done_o            (done_o),
    .read_value_o      (read_value_o),
    .halted_o          (halted_o),
    .cycle_count_o     (cycle_count_o),
    .program_counter_o (program_counter_o)
  );

  // predicted machine state
  logic [31:0] imem_m [int];
  logic [31:0] dmem_m [int];
  logic [15:0] loaded_addrs [$];
  logic [31:0] rf_m [RegCount];
  logic [15:0] pc_m, ifid_pc_m;
  logic [31:0] cycles_m;
  logic [31:0] ifid_ir_m, idex_ir_m, idex_va_m, idex_vb_m, idex_pc1_m, idex_off_m;
  logic [31:0] exmem_ir_m, exmem_tgt_m, exmem_eq_m, exmem_alu_m, exmem_vb_m;
  logic [31:0] memwb_ir_m, memwb_d_m, wbend_ir_m, wbend_d_m;

  cpu_res_t expected_q [$];
  int       err_cnt;
  bit       no_idle;
  bit       allow_halt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] encode(logic [2:0] op, logic [2:0] ra, logic [2:0] rb,
                                         logic [15:0] off);
    return {7'd0, op, ra, rb, off};
  endfunction

  function automatic logic [31:0] mem_rd(ref logic [31:0] m [int], input logic [15:0] a);
    return m.exists(a) ? m[a] : 32'd0;
  endfunction

  // forward one producer into the operands of the instruction in execute
  function automatic void fwd_operand(logic [31:0] src, bit with_lw, logic [31:0] val,
                                      logic [31:0] usr, inout logic [31:0] a,
                                      inout logic [31:0] b);
    logic [2:0] d;
    logic       w;
    w = 1'b0;
    d = src[2:0];
    if (src[24:22] == OP_ADD || src[24:22] == OP_NOR) begin
      w = 1'b1;
    end else if (with_lw && src[24:22] == OP_LW) begin
      w = 1'b1;
      d = src[18:16];
    end
    if (w && d == usr[21:19]) a = val;
    if (w && d == usr[18:16]) b = val;
  endfunction

  // one clock of the pipeline
  function automatic void pipe_clock();
    bit          taken, stall;
    logic [15:0] n_pc, n_ifid_pc;
    logic [31:0] n_ifid, f, n_idex, n_va, n_vb, n_pc1, n_off;
    logic [31:0] n_exmem, n_tgt, n_eq, n_alu, a, b, wd;
    logic [2:0]  fo, o, d;
    taken = exmem_ir_m[24:22] == OP_BEQ && exmem_eq_m != 0;
    wd = 32'd0;
    stall = 1'b0;
    cycles_m = cycles_m + 32'd1;
    // fetch with load-use bubble
    if (taken) begin
      n_pc = exmem_tgt_m[15:0];
      n_ifid_pc = n_pc;
      n_ifid = NoopWord;
    end else begin
      f = mem_rd(imem_m, pc_m);
      fo = f[24:22];
      if (ifid_ir_m[24:22] == OP_LW) begin
        d = ifid_ir_m[18:16];
        if (fo == OP_ADD || fo == OP_NOR || fo == OP_SW || fo == OP_BEQ)
          stall = d == f[21:19] || d == f[18:16];
        else if (fo == OP_LW)
          stall = d == f[21:19];
      end
      n_ifid_pc = pc_m + 16'd1;
      n_pc = stall ? pc_m : n_ifid_pc;
      n_ifid = stall ? NoopWord : f;
    end
    // decode
    n_off = ifid_ir_m[24:22] == OP_NOOP ? 32'd0 : {{16{ifid_ir_m[15]}}, ifid_ir_m[15:0]};
    n_pc1 = {16'd0, ifid_pc_m};
    n_va = rf_m[ifid_ir_m[21:19]];
    n_vb = rf_m[ifid_ir_m[18:16]];
    n_idex = taken ? NoopWord : ifid_ir_m;
    // execute, oldest producer first so the newest wins
    a = idex_va_m;
    b = idex_vb_m;
    fwd_operand(wbend_ir_m, 1'b1, wbend_d_m, idex_ir_m, a, b);
    fwd_operand(memwb_ir_m, 1'b1, memwb_d_m, idex_ir_m, a, b);
    fwd_operand(exmem_ir_m, 1'b0, exmem_alu_m, idex_ir_m, a, b);
    o = idex_ir_m[24:22];
    if (o == OP_ADD) n_alu = a + b;
    else if (o == OP_NOR) n_alu = ~(a | b);
    else if (o == OP_LW || o == OP_SW) n_alu = a + idex_off_m;
    else n_alu = 32'd0;
    n_eq = a == b ? 32'd1 : 32'd0;
    n_tgt = idex_off_m + idex_pc1_m;
    n_exmem = taken ? NoopWord : idex_ir_m;
    // memory
    o = exmem_ir_m[24:22];
    if (o == OP_ADD || o == OP_NOR) wd = exmem_alu_m;
    else if (o == OP_LW) wd = mem_rd(dmem_m, exmem_alu_m[15:0]);
    else if (o == OP_SW) dmem_m[exmem_alu_m[15:0]] = exmem_vb_m;
    // writeback
    o = memwb_ir_m[24:22];
    if (o == OP_ADD || o == OP_NOR) rf_m[memwb_ir_m[2:0]] = memwb_d_m;
    else if (o == OP_LW) rf_m[memwb_ir_m[18:16]] = memwb_d_m;
    wbend_ir_m = memwb_ir_m;
    wbend_d_m = memwb_d_m;
    memwb_ir_m = exmem_ir_m;
    memwb_d_m = wd;
    exmem_ir_m = n_exmem;
    exmem_tgt_m = n_tgt;
    exmem_eq_m = n_eq;
    exmem_alu_m = n_alu;
    exmem_vb_m = b;
    idex_ir_m = n_idex;
    idex_va_m = n_va;
    idex_vb_m = n_vb;
    idex_pc1_m = n_pc1;
    idex_off_m = n_off;
    ifid_ir_m = n_ifid;
    ifid_pc_m = n_ifid_pc;
    pc_m = n_pc;
  endfunction

  // apply one transaction to the predicted state and give its result
  function automatic cpu_res_t cpu_predict(logic [1:0] f, logic [15:0] a, logic [31:0] d);
    cpu_res_t r;
    r.read_value = 32'd0;
    case (f)
      FN_LOAD: begin
        imem_m[a] = d;
        dmem_m[a] = d;
        loaded_addrs.push_back(a);
      end
      FN_STEP: begin
        if (memwb_ir_m[24:22] != OP_HALT) pipe_clock();
      end
      FN_RDMEM: r.read_value = mem_rd(dmem_m, a);
      default: r.read_value = a < RegCount ? rf_m[a[2:0]] : 32'd0;
    endcase
    r.halted = memwb_ir_m[24:22] == OP_HALT;
    r.cycle_count = cycles_m;
    r.program_counter = pc_m;
    return r;
  endfunction

  // random instruction word, halt only when enabled
  function automatic logic [31:0] rand_instr();
    logic [2:0]  op;
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0, 1: op = OP_ADD;
      2:    op = OP_NOR;
      3, 4: op = OP_LW;
      5:    op = OP_SW;
      6, 7: op = OP_BEQ;
      8:    op = OpJalr;
      default: op = OP_NOOP;
    endcase
    if (allow_halt && $urandom_range(0, 3) == 0) op = OP_HALT;
    w = $urandom();
    w[24:22] = op;
    if ($urandom_range(0, 3) != 0) w[15:0] = 16'($urandom_range(0, 40) - 8);
    if ($urandom_range(0, 7) == 0) w = $urandom();
    if (!allow_halt && w[24:22] == OP_HALT) w[24:22] = OP_NOOP;
    return w;
  endfunction

  // mismatch report
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // issue one transaction and record its expected result
  task automatic send(logic [1:0] f, logic [15:0] a, logic [31:0] d, bit typed,
                      cpu_res_t want);
    int       gap;
    cpu_res_t r;
    gap = no_idle ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    address_i <= a;
    word_data_i <= d;
    do @(posedge clk_i); while (busy_o);
    r = cpu_predict(f, a, d);
    expected_q.push_back(typed ? want : r);
  endtask

  // step, first loading any word the next clock would use unwritten
  task automatic step_cpu();
    cpu_res_t none;
    none = '0;
    if (memwb_ir_m[24:22] != OP_HALT) begin
      if (!(exmem_ir_m[24:22] == OP_BEQ && exmem_eq_m != 0) && !imem_m.exists(pc_m))
        send(FN_LOAD, pc_m, rand_instr(), 1'b0, none);
      if (exmem_ir_m[24:22] == OP_LW && !dmem_m.exists(exmem_alu_m[15:0]))
        send(FN_LOAD, exmem_alu_m[15:0], rand_instr(), 1'b0, none);
    end
    send(FN_STEP, 16'($urandom()), $urandom(), 1'b0, none);
  endtask

  // result checker
  always @(posedge clk_i) begin
    cpu_res_t w;
    if (done_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", read_value_o, 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (read_value_o !== w.read_value) report("read_value", read_value_o, w.read_value);
        if (halted_o !== w.halted) report("halted", {31'd0, halted_o}, {31'd0, w.halted});
        if (cycle_count_o !== w.cycle_count)
          report("cycle_count", cycle_count_o, w.cycle_count);
        if (program_counter_o !== w.program_counter)
          report("program_counter", {16'd0, program_counter_o}, {16'd0, w.program_counter});
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    cpu_res_t  none;
    int        k, waited, pick;
    none = '0;
    err_cnt = 0;
    no_idle = 1'b0;
    allow_halt = 1'b0;
    start_i = 1'b0;
    func_i = FN_LOAD;
    address_i = '0;
    word_data_i = '0;
    rst_ni = 1'b0;
    foreach (rf_m[i]) rf_m[i] = '0;
    pc_m = '0; ifid_pc_m = '0; cycles_m = '0;
    ifid_ir_m = NoopWord; idex_ir_m = NoopWord; exmem_ir_m = NoopWord;
    memwb_ir_m = NoopWord; wbend_ir_m = NoopWord;
    idex_va_m = '0; idex_vb_m = '0; idex_pc1_m = '0; idex_off_m = '0;
    exmem_tgt_m = '0; exmem_eq_m = '0; exmem_alu_m = '0; exmem_vb_m = '0;
    memwb_d_m = '0; wbend_d_m = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset values, extremes, then a short program
    rows.push_back('{FN_RDREG, 16'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 32'd0, 16'd0}});
    rows.push_back('{FN_RDREG, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 32'd0, 16'd0}});
    rows.push_back('{FN_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 32'd0, 16'd0}});
    rows.push_back('{FN_RDMEM, 16'hFFFF, 32'd0, 1'b1,
                     '{32'hFFFF_FFFF, 1'b0, 32'd0, 16'd0}});
    rows.push_back('{FN_LOAD, 16'd20, 32'h7FFF_FFFF, 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd0, encode(OP_LW, 3'd0, 3'd1, 16'd20), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd1, encode(OP_ADD, 3'd1, 3'd1, 16'd2), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd2, encode(OP_NOR, 3'd2, 3'd1, 16'd3), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd3, encode(OP_SW, 3'd0, 3'd3, 16'd21), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd4, encode(OP_BEQ, 3'd1, 3'd1, 16'd2), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd5, encode(OP_ADD, 3'd1, 3'd2, 16'd5), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd6, encode(OpJalr, 3'd1, 3'd2, 16'd0), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd7, encode(OP_LW, 3'd0, 3'd4, 16'hFFFF), 1'b0, none});
    rows.push_back('{FN_LOAD, 16'd8, encode(OP_ADD, 3'd4, 3'd1, 16'd6), 1'b0, none});
    for (k = 0; k < 10; k++) rows.push_back('{FN_STEP, 16'd0, 32'd0, 1'b0, none});
    rows.push_back('{FN_RDMEM, 16'd21, 32'd0, 1'b0, none});
    rows.push_back('{FN_RDREG, 16'd3, 32'd0, 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.func == FN_STEP) step_cpu();
      else send(row.func, row.addr, row.data, row.typed, row.want);
    end

    // random part, mostly program steps with loads and reads mixed in
    for (k = 0; k < 280; k++) begin
      no_idle = k >= 60 && k < 100;
      if (k == 130) begin
        start_i <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      // plant halts near the end so the halted state is reached
      if (k == 250) begin
        allow_halt = 1'b1;
        for (int j = 0; j < 3; j++)
          send(FN_LOAD, pc_m + j[15:0], encode(OP_HALT, 3'd0, 3'd0, 16'd0), 1'b0, none);
      end
      pick = int'($urandom_range(0, 19));
      if (pick < 13) begin
        step_cpu();
      end else if (pick < 16) begin
        send(FN_LOAD,
             $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 63)),
             $urandom_range(0, 1) ? rand_instr() : $urandom(), 1'b0, none);
      end else if (pick < 18) begin
        send(FN_RDREG,
             $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 9)),
             $urandom(), 1'b0, none);
      end else begin
        send(FN_RDMEM, loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)],
             $urandom(), 1'b0, none);
      end
    end
    start_i <= 1'b0;

    // drain
    waited = 0;
    while (expected_q.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fspc_pkg.sv
rtl/fspc_ctrl.sv
rtl/fspc_datapath.sv
rtl/five_stage_pipelined_cpu.sv
rtl/fspc_checker.sv
tb/sv/tb_five_stage_pipelined_cpu.sv
